### hw/rtl/apsp_pkg.sv
// Shared constants for the all-pairs shortest path block.
package apsp_pkg;

    // Width of one stored distance; all ones marks an unreachable pair
    localparam int DIST_BITS       = 20;
    localparam int NODES_DEF       = 8;
    localparam int WEIGHT_BITS_DEF = 16;

    // Fixed port field widths
    localparam int VTX_BITS    = 3;
    localparam int WIN_BITS    = 16;
    localparam int S_DATA_BITS = 24;
    localparam int M_DATA_BITS = 24;

    localparam logic [DIST_BITS-1:0] DIST_INF = {DIST_BITS{1'b1}};

    // Item kinds carried in s_tuser
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

endpackage

### hw/rtl/apsp_wmem.sv
// Edge weight store with per-entry valid bits; unwritten entries read as no edge.
module apsp_wmem #(
    parameter int NODES       = apsp_pkg::NODES_DEF,
    parameter int WEIGHT_BITS = apsp_pkg::WEIGHT_BITS_DEF,
    parameter int AW          = $clog2(NODES * NODES)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   wr_en,
    input  logic [AW-1:0]          wr_addr,
    input  logic [WEIGHT_BITS-1:0] wr_data,
    input  logic [AW-1:0]          rd_addr,
    output logic [WEIGHT_BITS-1:0] rd_data
);
    import apsp_pkg::*;

    localparam int DEPTH = NODES * NODES;
    localparam logic [WEIGHT_BITS-1:0] NO_EDGE = {WEIGHT_BITS{1'b1}};

    logic [WEIGHT_BITS-1:0] mem [DEPTH];
    logic [DEPTH-1:0]       vld_reg;
    logic [WEIGHT_BITS-1:0] rd_mem_reg;
    logic                   rd_vld_reg;

    // Storage write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_mem_reg <= mem[rd_addr];
    end

    // Valid bits, cleared at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    assign rd_data = rd_vld_reg ? rd_mem_reg : NO_EDGE;

endmodule

### hw/rtl/apsp_cell.sv
// One distance cell of the rotating chain: holds an entry and takes its neighbor's.
module apsp_cell (
    input  logic                           aclk,
    input  logic                           shift_en,
    input  logic [apsp_pkg::DIST_BITS-1:0] d_in,
    output logic [apsp_pkg::DIST_BITS-1:0] d_out
);
    import apsp_pkg::*;

    logic [DIST_BITS-1:0] dist_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            dist_reg <= d_in;
        end
    end

    assign d_out = dist_reg;

endmodule

### hw/rtl/apsp_relax.sv
// One relaxation step: min(d_ij, d_ik + d_kj), skipping unreachable legs.
module apsp_relax (
    input  logic [apsp_pkg::DIST_BITS-1:0] d_ij,
    input  logic [apsp_pkg::DIST_BITS-1:0] d_ik,
    input  logic [apsp_pkg::DIST_BITS-1:0] d_kj,
    output logic [apsp_pkg::DIST_BITS-1:0] d_new
);
    import apsp_pkg::*;

    logic [DIST_BITS:0]   sum;
    logic [DIST_BITS-1:0] sum_sat;

    always_comb begin
        sum     = {1'b0, d_ik} + {1'b0, d_kj};
        // hold long paths just below the unreachable code
        sum_sat = (sum >= {1'b0, DIST_INF}) ? DIST_INF - 1'b1 : sum[DIST_BITS-1:0];
        if (d_ik == DIST_INF || d_kj == DIST_INF) begin
            d_new = d_ij;
        end else begin
            d_new = (sum_sat < d_ij) ? sum_sat : d_ij;
        end
    end

endmodule

### hw/rtl/all_pairs_shortest_path.sv
// All-pairs shortest path (Floyd-Warshall) over a chain of distance cells.
//
// s_ channel: one item per transfer. s_tuser is the item kind (0 = store one
// edge weight, 1 = query one distance). A write is taken and gives
// no result. A query gives one result on the m_ channel.
// When the closure is current, a query waits for one full rotation of the
// distance chain to reach the wanted entry. After any in-range write the
// next query first rebuilds the closure: it loads the weights from the
// weight store, then relaxes one compare-add per cycle as the chain
// rotates past the single relax unit.
// A query for a vertex out of range skips all of this and answers unreachable.
// The block works on one item at a time; s_tready is high while it is idle,
// also when a finished result still waits in the m_ register.
// Reset clears all weights to no edge and marks the closure stale.
// When the receiver stalls, the result holds in the output register and a
// following query waits there until it is taken.
module all_pairs_shortest_path #(
    parameter int NODES       = apsp_pkg::NODES_DEF,
    parameter int WEIGHT_BITS = apsp_pkg::WEIGHT_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // s_tdata: row[2:0], col[5:3], weight[21:6], zero fill
    input  logic [apsp_pkg::S_DATA_BITS-1:0] s_tdata,
    // s_tuser: action[0]
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata: distance[19:0], reachable[20], zero fill
    output logic [apsp_pkg::M_DATA_BITS-1:0] m_tdata
);
    import apsp_pkg::*;

    localparam int CELLS = NODES * NODES;
    localparam int AW    = $clog2(CELLS);
    localparam int IW    = $clog2(NODES);
    localparam int CW    = (WEIGHT_BITS > DIST_BITS) ? WEIGHT_BITS : DIST_BITS;
    localparam logic [WEIGHT_BITS-1:0] NO_EDGE = {WEIGHT_BITS{1'b1}};

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_LOAD  = 5'b00010,
        ST_RELAX = 5'b00100,
        ST_SEEK  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t               state_reg;
    logic [IW-1:0]        i_reg, j_reg, k_reg;
    logic [AW-1:0]        lin_reg, tgt_reg;
    logic                 iss_done_reg;
    logic                 ld_v_reg;
    logic [IW-1:0]        ld_i_reg, ld_j_reg;
    logic                 stale_reg;
    logic [DIST_BITS-1:0] res_reg;
    logic                 m_tvalid_reg;
    logic [M_DATA_BITS-1:0] m_tdata_reg;

    logic [DIST_BITS-1:0] prow_cur_reg [NODES];
    logic [DIST_BITS-1:0] pcol_cur_reg [NODES];
    logic [DIST_BITS-1:0] prow_nxt_reg [NODES];
    logic [DIST_BITS-1:0] pcol_nxt_reg [NODES];
    logic [DIST_BITS-1:0] prow_nxt_next [NODES];
    logic [DIST_BITS-1:0] pcol_nxt_next [NODES];

    logic [DIST_BITS-1:0] cell_q [CELLS];
    logic [DIST_BITS-1:0] tail_in;
    logic                 shift_en;

    logic [VTX_BITS-1:0]    s_row, s_col;
    logic [WIN_BITS-1:0]    s_weight;
    logic                   s_xfer, in_range;
    logic [AW-1:0]          s_addr;
    logic [WEIGHT_BITS-1:0] rd_w;
    logic [CW-1:0]          rd_w_ext;
    logic [DIST_BITS-1:0]   ld_dist, relaxed, head;
    logic                   i_last, j_last, k_last, ld_last, lin_last;
    logic                   row_is_next, col_is_next;

    // Input field unpacking
    assign s_row    = s_tdata[VTX_BITS-1:0];
    assign s_col    = s_tdata[2*VTX_BITS-1:VTX_BITS];
    assign s_weight = s_tdata[2*VTX_BITS+WIN_BITS-1:2*VTX_BITS];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign in_range = (32'(s_row) < NODES) && (32'(s_col) < NODES);
    assign s_addr   = AW'(AW'(s_row) * AW'(NODES) + AW'(s_col));

    // Weight store
    apsp_wmem #(
        .NODES       (NODES),
        .WEIGHT_BITS (WEIGHT_BITS),
        .AW          (AW)
    ) u_wmem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (s_xfer && s_tuser == ACT_WRITE && in_range),
        .wr_addr (s_addr),
        .wr_data (WEIGHT_BITS'(s_weight)),
        .rd_addr (lin_reg),
        .rd_data (rd_w)
    );

    // Weight to initial distance
    always_comb begin
        rd_w_ext = CW'(rd_w);
        if (ld_i_reg == ld_j_reg) begin
            ld_dist = '0;
        end else if (rd_w == NO_EDGE) begin
            ld_dist = DIST_INF;
        end else if (rd_w_ext >= CW'(DIST_INF)) begin
            ld_dist = DIST_INF - 1'b1;
        end else begin
            ld_dist = DIST_BITS'(rd_w_ext);
        end
    end

    // Distance chain; cell 0 is the head
    assign head = cell_q[0];

    for (genvar p = 0; p < CELLS; p++) begin : g_chain
        if (p == CELLS - 1) begin : g_tail
            apsp_cell u_cell (
                .aclk     (aclk),
                .shift_en (shift_en),
                .d_in     (tail_in),
                .d_out    (cell_q[p])
            );
        end else begin : g_body
            apsp_cell u_cell (
                .aclk     (aclk),
                .shift_en (shift_en),
                .d_in     (cell_q[p+1]),
                .d_out    (cell_q[p])
            );
        end
    end

    apsp_relax u_relax (
        .d_ij  (head),
        .d_ik  (pcol_cur_reg[i_reg]),
        .d_kj  (prow_cur_reg[j_reg]),
        .d_new (relaxed)
    );

    assign shift_en = (state_reg == ST_LOAD && ld_v_reg) || state_reg == ST_RELAX
                      || state_reg == ST_SEEK;

    always_comb begin
        unique case (state_reg)
            ST_LOAD:  tail_in = ld_dist;
            ST_RELAX: tail_in = relaxed;
            default:  tail_in = head;
        endcase
    end

    // Loop bounds
    assign i_last   = (i_reg == IW'(NODES - 1));
    assign j_last   = (j_reg == IW'(NODES - 1));
    assign k_last   = (k_reg == IW'(NODES - 1));
    assign ld_last  = (ld_i_reg == IW'(NODES - 1)) && (ld_j_reg == IW'(NODES - 1));
    assign lin_last = (lin_reg == AW'(CELLS - 1));
    assign row_is_next = ((IW+1)'(i_reg) == (IW+1)'(k_reg) + (IW+1)'(1));
    assign col_is_next = ((IW+1)'(j_reg) == (IW+1)'(k_reg) + (IW+1)'(1));

    // Pivot row and column for the next pass, caught as relaxed entries leave
    always_comb begin
        prow_nxt_next = prow_nxt_reg;
        pcol_nxt_next = pcol_nxt_reg;
        if (state_reg == ST_RELAX) begin
            if (row_is_next) begin
                prow_nxt_next[j_reg] = relaxed;
            end
            if (col_is_next) begin
                pcol_nxt_next[i_reg] = relaxed;
            end
        end
    end

    always_ff @(posedge aclk) begin
        prow_nxt_reg <= prow_nxt_next;
        pcol_nxt_reg <= pcol_nxt_next;
        if (state_reg == ST_LOAD && ld_v_reg) begin
            if (ld_i_reg == '0) begin
                prow_cur_reg[ld_j_reg] <= ld_dist;
            end
            if (ld_j_reg == '0) begin
                pcol_cur_reg[ld_i_reg] <= ld_dist;
            end
        end else if (state_reg == ST_RELAX && i_last && j_last) begin
            prow_cur_reg <= prow_nxt_next;
            pcol_cur_reg <= pcol_nxt_next;
        end
    end

    // Load pipeline tags and result payload
    always_ff @(posedge aclk) begin
        ld_i_reg <= i_reg;
        ld_j_reg <= j_reg;
        if (s_xfer) begin
            tgt_reg <= s_addr;
            if (!in_range) begin
                res_reg <= DIST_INF;
            end
        end else if (state_reg == ST_SEEK && lin_reg == tgt_reg) begin
            res_reg <= head;
        end
        if (state_reg == ST_DONE && (!m_tvalid_reg || m_tready)) begin
            m_tdata_reg <= M_DATA_BITS'({res_reg != DIST_INF, res_reg});
        end
    end

    // Control sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            stale_reg    <= 1'b1;
            i_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            lin_reg      <= '0;
            iss_done_reg <= 1'b0;
            ld_v_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            ld_v_reg <= (state_reg == ST_LOAD) && !iss_done_reg;
            // output register: load a finished result, or drop one that was taken
            if (state_reg == ST_DONE && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    i_reg        <= '0;
                    j_reg        <= '0;
                    k_reg        <= '0;
                    lin_reg      <= '0;
                    iss_done_reg <= 1'b0;
                    if (s_xfer) begin
                        if (s_tuser == ACT_WRITE) begin
                            if (in_range) begin
                                stale_reg <= 1'b1;
                            end
                        end else if (!in_range) begin
                            state_reg <= ST_DONE;
                        end else if (stale_reg) begin
                            state_reg <= ST_LOAD;
                        end else begin
                            state_reg <= ST_SEEK;
                        end
                    end
                end
                ST_LOAD: begin
                    // issue one weight read per cycle, shift it in on the following cycle
                    if (!iss_done_reg) begin
                        lin_reg <= lin_reg + 1'b1;
                        j_reg   <= j_last ? '0 : j_reg + 1'b1;
                        if (j_last) begin
                            i_reg <= i_last ? '0 : i_reg + 1'b1;
                        end
                        if (i_last && j_last) begin
                            iss_done_reg <= 1'b1;
                        end
                    end
                    if (ld_v_reg && ld_last) begin
                        state_reg <= ST_RELAX;
                        i_reg     <= '0;
                        j_reg     <= '0;
                    end
                end
                ST_RELAX: begin
                    j_reg <= j_last ? '0 : j_reg + 1'b1;
                    if (j_last) begin
                        i_reg <= i_last ? '0 : i_reg + 1'b1;
                    end
                    if (i_last && j_last) begin
                        if (k_last) begin
                            state_reg <= ST_SEEK;
                            stale_reg <= 1'b0;
                            lin_reg   <= '0;
                        end else begin
                            k_reg <= k_reg + 1'b1;
                        end
                    end
                end
                ST_SEEK: begin
                    // one full turn leaves the chain aligned again
                    lin_reg <= lin_last ? '0 : lin_reg + 1'b1;
                    if (lin_last) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks
    a_state_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("state register not one-hot");

    a_reach_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[DIST_BITS] == (m_tdata[DIST_BITS-1:0] != DIST_INF)))
        else $error("reachable flag disagrees with distance");

    a_seek_fresh: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEEK) |-> !stale_reg)
        else $error("lookup on a stale closure");

    a_closure_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RELAX && i_last && j_last && k_last) |=>
            (state_reg == ST_SEEK && !stale_reg && lin_reg == '0))
        else $error("closure did not hand over to lookup");

endmodule
